>>> rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal block.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // default coordinate width of one vertex component
  localparam int DEF_COORD_BITS       = 24;
  // default fraction bits of one normal component
  localparam int DEF_NORMAL_FRAC_BITS = 15;
  // pipeline depth of the cross product / sum of squares front end
  localparam int FRONT_STAGES         = 8;
  // entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH          = 4;

endpackage

>>> rtl/tfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_front
// Edge vectors, exact cross product, squared components and their sum.
// ----------------------------------------------------------------------------
module tfn_front #(
  parameter int COORD_BITS = tfn_pkg::DEF_COORD_BITS,
  localparam int DW    = COORD_BITS + 1,
  localparam int MW    = 2 * DW,
  localparam int SQW   = 2 * MW,
  localparam int SW    = SQW + 2,
  localparam int REC_W = 4 + 3 * SQW + SW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] v0_x,
  input  logic signed [COORD_BITS-1:0] v0_y,
  input  logic signed [COORD_BITS-1:0] v0_z,
  input  logic signed [COORD_BITS-1:0] v1_x,
  input  logic signed [COORD_BITS-1:0] v1_y,
  input  logic signed [COORD_BITS-1:0] v1_z,
  input  logic signed [COORD_BITS-1:0] v2_x,
  input  logic signed [COORD_BITS-1:0] v2_y,
  input  logic signed [COORD_BITS-1:0] v2_z,
  output logic                         rec_valid,
  input  logic                         rec_ready,
  output logic [REC_W-1:0]             rec
);

  localparam int NS  = tfn_pkg::FRONT_STAGES;
  localparam int CRW = MW + 1;
  localparam int H   = MW / 2;

  logic          adv;
  logic [NS-1:0] vld;

  // stage 0: captured vertices
  logic signed [COORD_BITS-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
  // stage 1: edges a = v1 - v0, b = v2 - v0
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  // stage 2: products
  logic signed [MW-1:0] p1, p2, p3, p4, p5, p6;
  // stage 3: cross product
  logic signed [CRW-1:0] nx, ny, nz;
  logic signed [CRW-1:0] nx_abs, ny_abs, nz_abs;
  // stage 4: magnitude and sign
  logic [MW-1:0] mx, my, mz;
  logic [2:0]    neg4, neg5, neg6, neg7;
  // stage 5: partial products of the squares
  logic [MW-1:0] llx, lhx, hhx, lly, lhy, hhy, llz, lhz, hhz;
  logic          deg5, deg6, deg7;
  // stage 6 and 7: squares and their sum
  logic [SQW-1:0] sqx6, sqy6, sqz6, sqx7, sqy7, sqz7;
  logic [SW-1:0]  s7;

  assign adv       = !vld[NS-1] || rec_ready;
  assign full      = !adv;
  assign rec_valid = vld[NS-1];
  assign rec       = {deg7, neg7, sqx7, sqy7, sqz7, s7};

  assign nx_abs = nx[CRW-1] ? -nx : nx;
  assign ny_abs = ny[CRW-1] ? -ny : ny;
  assign nz_abs = nz[CRW-1] ? -nz : nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0x <= v0_x; c0y <= v0_y; c0z <= v0_z;
      c1x <= v1_x; c1y <= v1_y; c1z <= v1_z;
      c2x <= v2_x; c2y <= v2_y; c2z <= v2_z;

      ax <= DW'(c1x) - DW'(c0x);
      ay <= DW'(c1y) - DW'(c0y);
      az <= DW'(c1z) - DW'(c0z);
      bx <= DW'(c2x) - DW'(c0x);
      by <= DW'(c2y) - DW'(c0y);
      bz <= DW'(c2z) - DW'(c0z);

      p1 <= ay * bz;
      p2 <= az * by;
      p3 <= az * bx;
      p4 <= ax * bz;
      p5 <= ax * by;
      p6 <= ay * bx;

      nx <= CRW'(p1) - CRW'(p2);
      ny <= CRW'(p3) - CRW'(p4);
      nz <= CRW'(p5) - CRW'(p6);

      // |n| <= 2^(MW-1), so it fits MW unsigned bits
      mx   <= nx_abs[MW-1:0];
      my   <= ny_abs[MW-1:0];
      mz   <= nz_abs[MW-1:0];
      neg4 <= {nx[CRW-1], ny[CRW-1], nz[CRW-1]};

      llx <= MW'(mx[H-1:0]) * MW'(mx[H-1:0]);
      lhx <= MW'(mx[H-1:0]) * MW'(mx[MW-1:H]);
      hhx <= MW'(mx[MW-1:H]) * MW'(mx[MW-1:H]);
      lly <= MW'(my[H-1:0]) * MW'(my[H-1:0]);
      lhy <= MW'(my[H-1:0]) * MW'(my[MW-1:H]);
      hhy <= MW'(my[MW-1:H]) * MW'(my[MW-1:H]);
      llz <= MW'(mz[H-1:0]) * MW'(mz[H-1:0]);
      lhz <= MW'(mz[H-1:0]) * MW'(mz[MW-1:H]);
      hhz <= MW'(mz[MW-1:H]) * MW'(mz[MW-1:H]);
      neg5 <= neg4;
      deg5 <= (mx == '0) && (my == '0) && (mz == '0);

      sqx6 <= {hhx, llx} + (SQW'(lhx) << (H + 1));
      sqy6 <= {hhy, lly} + (SQW'(lhy) << (H + 1));
      sqz6 <= {hhz, llz} + (SQW'(lhz) << (H + 1));
      neg6 <= neg5;
      deg6 <= deg5;

      s7   <= SW'(sqx6) + SW'(sqy6) + SW'(sqz6);
      sqx7 <= sqx6;
      sqy7 <= sqy6;
      sqz7 <= sqz6;
      neg7 <= neg6;
      deg7 <= deg6;
    end
  end

endmodule

>>> rtl/tfn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_queue
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module tfn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_take,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = tfn_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != (AW + 1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slot[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tfn_norm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_norm_lane
// One component: rounded magnitude of n * 2^F / |n|, one result bit a stage.
// ----------------------------------------------------------------------------
module tfn_norm_lane #(
  parameter int COORD_BITS       = tfn_pkg::DEF_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::DEF_NORMAL_FRAC_BITS,
  localparam int DW  = COORD_BITS + 1,
  localparam int SQW = 4 * DW,
  localparam int SW  = SQW + 2
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [SQW-1:0]            sq,
  input  logic [SW-1:0]             s,
  input  logic                      neg,
  output logic [NORMAL_FRAC_BITS:0] mag,
  output logic                      neg_out
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NST = F + 2;
  localparam int RW  = SQW + 2 * F + 9;
  localparam int PW  = SW + F + 3;

  // Looking for the largest m with (2m-1)^2 * S <= sq * 2^(2F+2).
  // r = 2m-1, R = sq * 2^(2F+2) - r^2 * S, P = r * S.
  logic signed [RW-1:0] r_q [NST-1];
  logic signed [PW-1:0] p_q [NST-1];
  logic [SW-1:0]        s_q [NST-1];
  logic [F:0]           m_q [NST];
  logic                 n_q [NST];

  assign mag     = m_q[NST-1];
  assign neg_out = n_q[NST-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      r_q[0] <= $signed((RW'(sq) << (2 * F + 2)) - RW'(s));
      p_q[0] <= -$signed(PW'(s));
      s_q[0] <= s;
      m_q[0] <= '0;
      n_q[0] <= neg;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_stage
    localparam int B = F + 1 - j;
    localparam logic [F:0] BITV = (F + 1)'(1) << B;
    logic signed [RW-1:0] trial;
    logic signed [RW-1:0] diff;
    logic                 pass;

    // growing r by 2^(B+1) adds P*2^(B+2) + S*2^(2B+2) to r^2 * S
    assign trial = (RW'(p_q[j-1]) <<< (B + 2)) + $signed(RW'(s_q[j-1]) << (2 * B + 2));
    assign diff  = r_q[j-1] - trial;
    // once m reaches 1.0 no more bits may be added
    assign pass  = !diff[RW-1] && !m_q[j-1][F];

    always_ff @(posedge clk) begin
      if (adv) begin
        m_q[j] <= pass ? (m_q[j-1] | BITV) : m_q[j-1];
        n_q[j] <= n_q[j-1];
      end
    end

    if (j < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          r_q[j] <= pass ? diff : r_q[j-1];
          p_q[j] <= pass ? p_q[j-1] + $signed(PW'(s_q[j-1]) << (B + 1)) : p_q[j-1];
          s_q[j] <= s_q[j-1];
        end
      end
    end
  end

endmodule

>>> rtl/tfn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_back
// Three normalization lanes, saturation, sign and the degenerate override.
// ----------------------------------------------------------------------------
module tfn_back #(
  parameter int COORD_BITS       = tfn_pkg::DEF_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::DEF_NORMAL_FRAC_BITS,
  localparam int DW    = COORD_BITS + 1,
  localparam int SQW   = 4 * DW,
  localparam int SW    = SQW + 2,
  localparam int REC_W = 4 + 3 * SQW + SW,
  localparam int OW    = NORMAL_FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  logic [REC_W-1:0]     q_rec,
  input  logic                 pop,
  output logic                 empty,
  output logic signed [OW-1:0] normal_x,
  output logic signed [OW-1:0] normal_y,
  output logic signed [OW-1:0] normal_z,
  output logic                 degenerate
);

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int NL = F + 2;
  localparam logic signed [OW-1:0] ONE_SAT = {1'b0, {F{1'b1}}};

  logic           adv;
  logic [NL:0]    vld;
  logic           deg_q [NL];
  logic           rec_deg;
  logic [2:0]     rec_neg;
  logic [SQW-1:0] rec_sq [3];
  logic [SW-1:0]  rec_s;
  logic [F:0]     lane_mag [3];
  logic           lane_neg [3];
  logic signed [OW-1:0] comp [3];

  assign {rec_deg, rec_neg, rec_sq[0], rec_sq[1], rec_sq[2], rec_s} = q_rec;

  assign adv    = !vld[NL] || pop;
  assign q_take = adv && q_valid;
  assign empty  = !vld[NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NL-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_q[0] <= rec_deg;
      for (int i = 1; i < NL; i++) begin
        deg_q[i] <= deg_q[i-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [OW-1:0] sat;

    tfn_norm_lane #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .adv     (adv),
      .sq      (rec_sq[c]),
      .s       (rec_s),
      .neg     (rec_neg[2-c]),
      .mag     (lane_mag[c]),
      .neg_out (lane_neg[c])
    );

    // exactly 1.0 saturates to the largest code
    assign sat     = lane_mag[c][F] ? ONE_SAT : $signed({1'b0, lane_mag[c][F-1:0]});
    assign comp[c] = lane_neg[c] ? -sat : sat;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= deg_q[NL-1];
      if (deg_q[NL-1]) begin
        normal_x <= '0;
        normal_y <= '0;
        normal_z <= ONE_SAT;
      end else begin
        normal_x <= comp[0];
        normal_y <= comp[1];
        normal_z <= comp[2];
      end
    end
  end

endmodule

>>> rtl/triangle_face_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle in signed Q1.(NORMAL_FRAC_BITS) fixed point.
//
// Takes one triangle per beat (three vertices of signed COORD_BITS
// coordinates) and returns one beat per triangle, in order: the cross product
// (v1-v0) x (v2-v0) divided by its exact length, rounded to nearest with ties
// away from zero and saturated to +/-(2^F - 1). A zero cross product gives
// (0, 0, 2^F - 1) with degenerate set. A new triangle can be pushed every
// cycle while full is low; sustained rate is one beat per cycle while
// results are popped. From an accepted push to the result on the output
// ports lie 8 front stages (edges, cross product, squares in half-width
// partial products, sum of squares), the front/back queue, one setup
// stage, then one stage per result bit for the rounded square root
// division, and the output register. Both sides stall on their own: while
// the result port is not popped the queue between front and back fills, and
// full rises only when the front pipe also backs up.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
  parameter int COORD_BITS       = tfn_pkg::DEF_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::DEF_NORMAL_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [COORD_BITS-1:0]       v0_x,
  input  logic signed [COORD_BITS-1:0]       v0_y,
  input  logic signed [COORD_BITS-1:0]       v0_z,
  input  logic signed [COORD_BITS-1:0]       v1_x,
  input  logic signed [COORD_BITS-1:0]       v1_y,
  input  logic signed [COORD_BITS-1:0]       v1_z,
  input  logic signed [COORD_BITS-1:0]       v2_x,
  input  logic signed [COORD_BITS-1:0]       v2_y,
  input  logic signed [COORD_BITS-1:0]       v2_z,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [NORMAL_FRAC_BITS:0]   normal_x,
  output logic signed [NORMAL_FRAC_BITS:0]   normal_y,
  output logic signed [NORMAL_FRAC_BITS:0]   normal_z,
  output logic                               degenerate
);

  // record: degenerate, three signs, three squared components, their sum
  localparam int DW    = COORD_BITS + 1;
  localparam int SQW   = 4 * DW;
  localparam int SW    = SQW + 2;
  localparam int REC_W = 4 + 3 * SQW + SW;

  logic             f_valid, f_ready;
  logic [REC_W-1:0] f_rec;
  logic             q_valid, q_take;
  logic [REC_W-1:0] q_rec;

  tfn_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .v0_x      (v0_x),
    .v0_y      (v0_y),
    .v0_z      (v0_z),
    .v1_x      (v1_x),
    .v1_y      (v1_y),
    .v1_z      (v1_z),
    .v2_x      (v2_x),
    .v2_y      (v2_y),
    .v2_z      (v2_z),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec       (f_rec)
  );

  // decouples the front pipe from the normalization pipe
  tfn_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_rec),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_rec)
  );

  tfn_back #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .q_rec      (q_rec),
    .pop        (pop),
    .empty      (empty),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
  );

endmodule

>>> rtl/tfn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the result side of the face normal block.
// ----------------------------------------------------------------------------
module tfn_checker #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::DEF_NORMAL_FRAC_BITS,
  localparam int OW = NORMAL_FRAC_BITS + 1
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 empty,
  input logic                 pop,
  input logic signed [OW-1:0] normal_x,
  input logic signed [OW-1:0] normal_y,
  input logic signed [OW-1:0] normal_z,
  input logic                 degenerate
);

  localparam logic signed [OW-1:0] MAXV  = {1'b0, {NORMAL_FRAC_BITS{1'b1}}};
  localparam logic signed [OW-1:0] MINV  = {1'b1, {NORMAL_FRAC_BITS{1'b0}}};
  localparam logic signed [OW-1:0] HALFV = OW'(1) << (NORMAL_FRAC_BITS - 1);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // a waiting beat holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(normal_x) && $stable(normal_y)
                       && $stable(normal_z) && $stable(degenerate))
    else $error("waiting result changed");

  // degenerate beats carry the default normal
  a_degen: assert property (@(posedge clk) disable iff (rst)
    !empty && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == MAXV)
    else $error("degenerate beat without default normal");

  // saturation never gives the most negative code
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    !empty |-> normal_x != MINV && normal_y != MINV && normal_z != MINV)
    else $error("normal component out of range");

  // a unit vector has some component of at least 1/sqrt(3), so one must reach 1/2
  a_unit: assert property (@(posedge clk) disable iff (rst)
    !empty && !degenerate |-> normal_x >= HALFV || normal_x <= -HALFV
                           || normal_y >= HALFV || normal_y <= -HALFV
                           || normal_z >= HALFV || normal_z <= -HALFV)
    else $error("normal far too short");

endmodule

bind triangle_face_normal tfn_checker #(
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .degenerate (degenerate)
);
